FILE: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Shared item types, action and register codes, and sequencer types.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int ACC_W  = 48;
	localparam int ELEM_W = 16;

	localparam logic [2:0] ACT_WR_A    = 3'd0;
	localparam logic [2:0] ACT_WR_B    = 3'd1;
	localparam logic [2:0] ACT_WR_C    = 3'd2;
	localparam logic [2:0] ACT_COMPUTE = 3'd3;
	localparam logic [2:0] ACT_RD_C    = 3'd4;

	localparam logic [1:0] CFG_N_BLOCKS = 2'd0;
	localparam logic [1:0] CFG_M_BLOCKS = 2'd1;
	localparam logic [1:0] CFG_P_BLOCKS = 2'd2;

	typedef struct packed {
		logic [2:0]              action;
		logic [5:0]              row;
		logic [5:0]              col;
		logic signed [ACC_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] data;
		logic                    status;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_STORE
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic v;
		op_t  op;
	} tok_t;

endpackage

FILE: rtl/mma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/mma_cell.sv
// ----------------------------------------------------------------------------
// Accumulator cell
// One accumulator of the rotating ring; the tail cell applies the operation.
// ----------------------------------------------------------------------------
module mma_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic                       apply,
	input  mma_pkg::op_t               op,
	input  logic [mma_pkg::ACC_W-1:0]  cval,
	input  logic [mma_pkg::ACC_W-1:0]  prod,
	input  logic [mma_pkg::ACC_W-1:0]  d,
	output logic [mma_pkg::ACC_W-1:0]  q
);
	import mma_pkg::*;

	logic [ACC_W-1:0] upd;

	always_comb begin
		upd = d;
		if (apply) begin
			case (op)
				OP_LOAD: upd = cval;
				OP_MAC:  upd = d + prod;
				default: upd = d;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			q <= upd;
		end
	end
endmodule

FILE: rtl/mma_seq.sv
// ----------------------------------------------------------------------------
// Multiply sequencer
// Walks rows, column tiles and the inner dimension, issuing one word a cycle.
// ----------------------------------------------------------------------------
module mma_seq #(
	parameter int TILE    = 8,
	parameter int MAX_DIM = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [$clog2(MAX_DIM+1)-1:0]          nd,
	input  logic [$clog2(MAX_DIM+1)-1:0]          md,
	input  logic [$clog2(MAX_DIM+1)-1:0]          pd,
	input  logic                                  pipe_empty,
	output logic                                  busy,
	output logic                                  done,
	output mma_pkg::tok_t                         tok,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    c_addr
);
	import mma_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM+1);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
	localparam int T_W    = $clog2(TILE);

	function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
	endfunction

	state_t           state_q, state_d;
	op_t              phase_q;
	logic [DIM_W-1:0] i_q, jb_q, k_q;
	logic [T_W-1:0]   t_q;
	logic             t_last, k_last, j_last, i_last, run_end;
	logic [IDX_W-1:0] col;

	assign t_last  = t_q == T_W'(TILE-1);
	assign k_last  = ({1'b0, k_q} + (DIM_W+1)'(1)) == {1'b0, pd};
	assign j_last  = ({1'b0, jb_q} + (DIM_W+1)'(TILE)) >= {1'b0, md};
	assign i_last  = ({1'b0, i_q} + (DIM_W+1)'(1)) >= {1'b0, nd};
	assign run_end = t_last && phase_q == OP_STORE && j_last && i_last;

	assign col    = jb_q[IDX_W-1:0] + IDX_W'(t_q);
	assign a_addr = addr_of(i_q[IDX_W-1:0], k_q[IDX_W-1:0]);
	assign b_addr = addr_of(k_q[IDX_W-1:0], col);
	assign c_addr = addr_of(i_q[IDX_W-1:0], col);

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (nd == '0 || md == '0) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				if (run_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = ST_IDLE;
					done    = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign tok.v  = state_q == ST_RUN;
	assign tok.op = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Each group of TILE words (loads, one k of products, stores) turns the ring once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= OP_LOAD;
			i_q     <= '0;
			jb_q    <= '0;
			k_q     <= '0;
			t_q     <= '0;
		end else if (start && state_q == ST_IDLE) begin
			phase_q <= OP_LOAD;
			i_q     <= '0;
			jb_q    <= '0;
			k_q     <= '0;
			t_q     <= '0;
		end else if (state_q == ST_RUN) begin
			if (!t_last) begin
				t_q <= t_q + T_W'(1);
			end else begin
				t_q <= '0;
				case (phase_q)
					OP_LOAD: begin
						k_q     <= '0;
						phase_q <= (pd == '0) ? OP_STORE : OP_MAC;
					end
					OP_MAC: begin
						if (k_last) begin
							phase_q <= OP_STORE;
						end else begin
							k_q <= k_q + DIM_W'(1);
						end
					end
					default: begin
						phase_q <= OP_LOAD;
						if (j_last) begin
							jb_q <= '0;
							i_q  <= i_q + DIM_W'(1);
						end else begin
							jb_q <= jb_q + DIM_W'(TILE);
						end
					end
				endcase
			end
		end
	end
endmodule

FILE: rtl/tiled_matrix_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// Tiled matrix multiply-accumulate core
// Element stores for A, B and C with C += A*B over a ring of accumulator cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               word
//  in        input      in_valid / in_ready     in_item (action, row, col, value)
//  out       output     out_valid / out_ready   out_item (data, status)
//  cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A write or read word passes through the result stage, which waits for the C read
// port, into the output register; no word goes in while the result stage is full.
// A compute word walks rows, column tiles and the inner dimension, one product a
// cycle, bound by the single read port of the B store.
// Reset clears control registers and sets each dimension to one block;
// the stores hold anything until written. One result may wait in the output
// register while the next word is taken; the input stalls while a compute runs.
module tiled_matrix_multiply_accumulate_core #(
	parameter int TILE    = 8,
	parameter int MAX_DIM = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mma_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mma_pkg::out_item_t  out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data
);
	import mma_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM+1);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
	localparam int NB     = MAX_DIM / TILE;
	localparam int CW     = (DIM_W > 6) ? DIM_W : 6;

	function automatic logic [DIM_W-1:0] dim_of(logic [3:0] v);
		int b;
		b = (32'(v) > NB) ? NB : 32'(v);
		return DIM_W'(b * TILE);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
	endfunction

	logic [DIM_W-1:0] nd_q, md_q, pd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= dim_of(4'd1);
			md_q <= dim_of(4'd1);
			pd_q <= dim_of(4'd1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_N_BLOCKS: nd_q <= dim_of(cfg_data);
				CFG_M_BLOCKS: md_q <= dim_of(cfg_data);
				CFG_P_BLOCKS: pd_q <= dim_of(cfg_data);
				default: ;
			endcase
		end
	end

	// Word decode.
	logic              acc_in, busy, done, start;
	logic [CW-1:0]     row_w, col_w;
	logic              row_n, row_p, col_p, col_m;
	logic              wr_a, wr_b, wr_c, rd_c, bad;
	logic [ADDR_W-1:0] item_addr;

	assign acc_in = in_valid && in_ready;
	assign row_w  = CW'(in_item.row);
	assign col_w  = CW'(in_item.col);
	assign row_n  = row_w < CW'(nd_q);
	assign row_p  = row_w < CW'(pd_q);
	assign col_p  = col_w < CW'(pd_q);
	assign col_m  = col_w < CW'(md_q);
	assign item_addr = addr_of(row_w[IDX_W-1:0], col_w[IDX_W-1:0]);

	always_comb begin
		wr_a = 1'b0;
		wr_b = 1'b0;
		wr_c = 1'b0;
		rd_c = 1'b0;
		bad  = 1'b0;
		case (in_item.action)
			ACT_WR_A: begin
				wr_a = row_n && col_p;
				bad  = !(row_n && col_p);
			end
			ACT_WR_B: begin
				wr_b = row_p && col_m;
				bad  = !(row_p && col_m);
			end
			ACT_WR_C: begin
				wr_c = row_n && col_m;
				bad  = !(row_n && col_m);
			end
			ACT_RD_C: begin
				rd_c = row_n && col_m;
				bad  = !(row_n && col_m);
			end
			default: ;
		endcase
	end

	assign start = acc_in && in_item.action == ACT_COMPUTE;

	// Sequencer and product pipeline.
	tok_t              tok, tok_s1, tok_s2;
	logic [ADDR_W-1:0] sa_addr, sb_addr, sc_addr, c_addr_s1, c_addr_s2;
	logic [ELEM_W-1:0] a_q, b_q;
	logic [ACC_W-1:0]  c_q, prod_s2, cval_s2;
	logic signed [2*ELEM_W-1:0] prod;
	logic              pipe_empty;

	assign pipe_empty = !tok_s1.v && !tok_s2.v;

	mma_seq #(.TILE(TILE), .MAX_DIM(MAX_DIM)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.nd         (nd_q),
		.md         (md_q),
		.pd         (pd_q),
		.pipe_empty (pipe_empty),
		.busy       (busy),
		.done       (done),
		.tok        (tok),
		.a_addr     (sa_addr),
		.b_addr     (sb_addr),
		.c_addr     (sc_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok;
			tok_s2 <= tok_s1;
		end
	end

	assign prod = $signed(a_q) * $signed(b_q);

	always_ff @(posedge clk) begin
		c_addr_s1 <= sc_addr;
		c_addr_s2 <= c_addr_s1;
		prod_s2   <= {{(ACC_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
		cval_s2   <= c_q;
	end

	// Ring of accumulators; the word at the head always belongs to cell zero.
	logic [ACC_W-1:0] acc [TILE];

	for (genvar t = 0; t < TILE; t++) begin : g_cell
		mma_cell u_cell (
			.clk   (clk),
			.shift (tok_s2.v),
			.apply (t == TILE-1),
			.op    (tok_s2.op),
			.cval  (cval_s2),
			.prod  (prod_s2),
			.d     (acc[(t + 1) % TILE]),
			.q     (acc[t])
		);
	end

	// Stores.
	logic              c_we, c_re;
	logic [ADDR_W-1:0] c_waddr, c_raddr;
	logic [ACC_W-1:0]  c_wdata;

	assign c_we    = busy ? (tok_s2.v && tok_s2.op == OP_STORE) : (acc_in && wr_c);
	assign c_waddr = busy ? c_addr_s2 : item_addr;
	assign c_wdata = busy ? acc[0] : ACC_W'(in_item.value);
	assign c_re    = busy ? (tok.v && tok.op == OP_LOAD) : (acc_in && rd_c);
	assign c_raddr = busy ? sc_addr : item_addr;

	mma_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM*MAX_DIM)) u_a_ram (
		.clk   (clk),
		.we    (acc_in && wr_a),
		.waddr (item_addr),
		.wdata (in_item.value[ELEM_W-1:0]),
		.re    (tok.v),
		.raddr (sa_addr),
		.rdata (a_q)
	);

	mma_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM*MAX_DIM)) u_b_ram (
		.clk   (clk),
		.we    (acc_in && wr_b),
		.waddr (item_addr),
		.wdata (in_item.value[ELEM_W-1:0]),
		.re    (tok.v),
		.raddr (sb_addr),
		.rdata (b_q)
	);

	mma_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DIM*MAX_DIM)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_q)
	);

	// Result stage and output register.
	logic s1_v_q, s1_rd_q, s1_st_q, out_v_q, s1_move;

	assign in_ready  = !busy && !s1_v_q;
	assign s1_move   = s1_v_q && (!out_v_q || out_ready);
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc_in && !start) begin
				s1_v_q <= 1'b1;
			end else if (done) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			s1_rd_q <= rd_c;
			s1_st_q <= bad;
		end else if (done) begin
			s1_rd_q <= 1'b0;
			s1_st_q <= 1'b0;
		end
		if (s1_move) begin
			out_item.data   <= s1_rd_q ? c_q : '0;
			out_item.status <= s1_st_q;
		end
	end
endmodule

FILE: rtl/mma_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the core's ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
module mma_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input mma_pkg::in_item_t   in_item,
	input logic                out_valid,
	input logic                out_ready,
	input mma_pkg::out_item_t  out_item
);
	import mma_pkg::*;

	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("result word changed while stalled");

	// A rejected address never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status |-> out_item.data == '0)
		else $error("flagged result carries data");

	// Once a compute word is taken, no further word is taken in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.action == ACT_COMPUTE |=> !in_ready)
		else $error("input taken during compute");
endmodule

bind tiled_matrix_multiply_accumulate_core mma_checker u_mma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
